// ===== rtl/core/squared_slack_partition_dp_assert.svh =====
// ---------------------------------------------------------------------------
// squared_slack_partition_dp assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef SQUARED_SLACK_PARTITION_DP_ASSERT_SVH
`define SQUARED_SLACK_PARTITION_DP_ASSERT_SVH

`ifndef ASSERT_OFF

// property that must hold at every edge out of reset
`define SSP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define SSP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ssp_pkg.sv =====
// ---------------------------------------------------------------------------
// ssp_pkg
// shared widths and constants of the squared slack partition block
// ---------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int ITEM_W         = 16;
    localparam int LIMIT_W        = 16;
    localparam int POS_W          = 30;
    localparam int CNT_W          = 13;
    localparam int H_W            = 64;
    localparam int COST_W         = 63;
    localparam int HULL_DEPTH_DEF = 4096;

    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/core/ssp_item_if.sv =====
// ---------------------------------------------------------------------------
// ssp_item_if
// input channel: one item length per beat with a sequence start flag
// ---------------------------------------------------------------------------
`default_nettype none

interface ssp_item_if;
    logic                      valid;
    logic                      ready;
    logic [ssp_pkg::ITEM_W-1:0] item_length;
    logic                      start_new;

    modport source (output valid, output item_length, output start_new, input ready);
    modport sink   (input valid, input item_length, input start_new, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssp_result_if.sv =====
// ---------------------------------------------------------------------------
// ssp_result_if
// result channel: best cost and sticky overflow per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface ssp_result_if;
    logic                       valid;
    logic                       ready;
    logic [ssp_pkg::COST_W-1:0] best_cost;
    logic                       overflow;

    modport source (output valid, output best_cost, output overflow, input ready);
    modport sink   (input valid, input best_cost, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/squared_slack_partition_dp.sv =====
// ---------------------------------------------------------------------------
// squared_slack_partition_dp
// streaming least squared-slack partition cost over a monotone convex hull
// ---------------------------------------------------------------------------
// One beat in per item length, one beat out per item with the least total
// cost of cutting all items so far into consecutive groups, each group
// costing (lengths + count - 1 - line_limit) squared. The hull of earlier
// split points sits in one single-port-read memory of HULL_DEPTH entries;
// every slope test is exact and runs through one shared 32x32 multiplier.
// The work per item grows with the points popped at the front and the
// back of the hull: each end runs one slope test per popped point, plus
// one that ends the pops unless a single point is left. The memory read
// latency and the shared multiplier set each test's length. A finished
// result waits in an output register so the next item can be taken
// while it is outstanding. Cost saturates at 2^63-1, and overflow stays
// set for the rest of a sequence once cost saturated, the hull was full
// or the item count hit 8191. line_limit is to be written only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

`include "squared_slack_partition_dp_assert.svh"

module squared_slack_partition_dp #(
    parameter int HULL_DEPTH = ssp_pkg::HULL_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ssp_pkg::LIMIT_W-1:0] i_cfg_data,
    ssp_item_if.sink                         i_item,
    ssp_result_if.source                     o_result
);

    localparam int AW    = $clog2(HULL_DEPTH);
    localparam int LW    = $clog2(HULL_DEPTH + 1);
    localparam int PW    = ssp_pkg::POS_W;
    localparam int HW    = ssp_pkg::H_W;
    localparam int BW    = PW + 1;
    localparam int PRW   = 96;
    localparam logic [AW-1:0] LAST  = AW'(HULL_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH = LW'(HULL_DEPTH);

    // one hull point: position sum and its cost
    typedef struct packed {
        logic [PW-1:0] pos;
        logic [HW-1:0] h;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK,
        S_F_RD0, S_F_RD1, S_F_L1, S_F_B, S_F_M0, S_F_M1, S_F_M2, S_F_CMP,
        S_E_RD, S_E_L, S_E_B, S_E_D, S_E_SQ, S_E_F, S_E_YM, S_E_YI,
        S_B_RD0, S_B_RD1, S_B_L, S_B_B, S_B_M0, S_B_M1, S_B_M2, S_B_AB,
        S_B_P0, S_B_P1, S_B_P2, S_B_P3, S_B_P4, S_B_CMP,
        S_PUSH, S_DONE
    } t_state;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] k);
        return (k == LAST) ? '0 : k + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] k);
        return (k == '0) ? LAST : k - AW'(1);
    endfunction

    t_state r_state;

    // sequence state
    logic [ssp_pkg::LIMIT_W-1:0] r_lim;
    logic [PW-1:0]               r_pos;
    logic [ssp_pkg::CNT_W-1:0]   r_cnt;
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               r_tail;
    logic [LW-1:0]               r_live;
    logic                        r_ovf;
    logic [ssp_pkg::ITEM_W-1:0]  r_len;

    // working registers
    t_entry        r_e0, r_e1;
    logic [BW-1:0] r_b0, r_b1, r_bi, r_d;
    logic [PW-1:0] r_m1, r_m2;
    logic [HW-1:0] r_y0, r_y1, r_yi, r_f, r_u, r_v, r_mp;
    logic          r_n1, r_n2;
    logic [PRW-1:0] r_p1, r_p2;
    logic [HW-1:0]  r_p1lo, r_p2lo;

    // output register
    logic                       r_ovalid;
    logic [ssp_pkg::COST_W-1:0] r_best;
    logic                       r_oovf;

    // hull memory
    t_entry        mem [HULL_DEPTH];
    t_entry        r_rd;
    logic [AW-1:0] rd_addr;
    logic          w_we;
    logic [AW-1:0] w_addr;
    t_entry        w_data;

    // shared multiplier
    logic [31:0]   mul_a, mul_b;
    logic [HW-1:0] w_prod;

    logic          w_accept;
    logic [HW-1:0] w_sum;
    logic          w_front;
    logic          w_s1, w_s2, w_less;
    logic [LW-1:0] w_span;

    assign w_accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid     = r_ovalid;
    assign o_result.best_cost = r_best;
    assign o_result.overflow  = r_oovf;

    assign w_prod = mul_a * mul_b;

    // read address follows the hull walk
    always_comb begin
        unique case (r_state)
            S_F_RD1: rd_addr = ring_next(r_head);
            S_B_RD0: rd_addr = r_tail;
            S_B_RD1: rd_addr = ring_prev(r_tail);
            default: rd_addr = r_head;
        endcase
    end

    // origin point on reset and on a new sequence, else the pushed point
    always_comb begin
        w_we   = 1'b0;
        w_addr = '0;
        w_data = '0;
        priority if (!i_rst_n) begin
            w_we = 1'b1;
        end else if (w_accept && i_item.start_new) begin
            w_we = 1'b1;
        end else if (r_state == S_PUSH && r_live < DEPTH) begin
            w_we       = 1'b1;
            w_addr     = ring_next(r_tail);
            w_data.pos = r_pos;
            w_data.h   = r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
        r_rd <= mem[rd_addr];
    end

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_F_M0, S_B_M0: begin mul_a = 32'(r_b0); mul_b = 32'(r_b0); end
            S_F_M1, S_B_M1: begin mul_a = 32'(r_b1); mul_b = 32'(r_b1); end
            S_F_M2: begin mul_a = 32'(r_pos);    mul_b = 32'(r_m1); end
            S_E_SQ: begin mul_a = 32'(r_d);      mul_b = 32'(r_d);  end
            S_E_YM: begin mul_a = 32'(r_bi);     mul_b = 32'(r_bi); end
            S_B_P0: begin mul_a = r_u[31:0];     mul_b = 32'(r_m1); end
            S_B_P1: begin mul_a = r_u[63:32];    mul_b = 32'(r_m1); end
            S_B_P2: begin mul_a = r_v[31:0];     mul_b = 32'(r_m2); end
            S_B_P3: begin mul_a = r_v[63:32];    mul_b = 32'(r_m2); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // new cost, saturating when bit 63 of the sum is set
    assign w_sum = r_e0.h + r_mp;

    // drop the head while the next point is strictly better
    assign w_front = (r_y1 < r_y0) || ((r_y1 - r_y0) < {r_mp[HW-2:0], 1'b0});

    // signed cross product compare on magnitudes
    assign w_s1   = r_n1 && (r_p1 != '0);
    assign w_s2   = r_n2 && (r_p2 != '0);
    assign w_less = (w_s1 != w_s2) ? w_s1 : (!w_s1 ? (r_p1 < r_p2) : (r_p1 > r_p2));

    assign w_span = (r_tail >= r_head) ? LW'(r_tail - r_head)
                                       : LW'({1'b0, r_tail} + LW'(HULL_DEPTH) - {1'b0, r_head});

    always_ff @(posedge i_clk) begin
        r_mp <= w_prod;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lim    <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_live   <= LW'(1);
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            // the done state reloads the output register itself
            if (r_ovalid && o_result.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_len <= i_item.item_length;
                        if (i_item.start_new) begin
                            r_pos  <= '0;
                            r_cnt  <= '0;
                            r_head <= '0;
                            r_tail <= '0;
                            r_live <= LW'(1);
                            r_ovf  <= 1'b0;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cnt >= ssp_pkg::COUNT_MAX) begin
                        // sequence too long: state kept, cost pinned
                        r_ovf   <= 1'b1;
                        r_f     <= HW'(ssp_pkg::COST_MAX);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_pos   <= r_pos + PW'(r_len) + PW'(1);
                        r_state <= S_F_RD0;
                    end
                end
                // front of the hull
                S_F_RD0: r_state <= (r_live > LW'(1)) ? S_F_RD1 : S_E_RD;
                S_F_RD1: begin
                    r_e0    <= r_rd;
                    r_state <= S_F_L1;
                end
                S_F_L1: begin
                    r_e1    <= r_rd;
                    r_state <= S_F_B;
                end
                S_F_B: begin
                    r_b0    <= BW'(r_e0.pos) + BW'(r_lim) + BW'(1);
                    r_b1    <= BW'(r_e1.pos) + BW'(r_lim) + BW'(1);
                    r_m1    <= r_e1.pos - r_e0.pos;
                    r_state <= S_F_M0;
                end
                S_F_M0: r_state <= S_F_M1;
                S_F_M1: begin
                    r_y0    <= r_e0.h + r_mp;
                    r_state <= S_F_M2;
                end
                S_F_M2: begin
                    r_y1    <= r_e1.h + r_mp;
                    r_state <= S_F_CMP;
                end
                S_F_CMP: begin
                    if (w_front) begin
                        r_head  <= ring_next(r_head);
                        r_live  <= r_live - LW'(1);
                        r_state <= S_F_RD0;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                // cost from the head point
                S_E_RD: r_state <= S_E_L;
                S_E_L: begin
                    r_e0    <= r_rd;
                    r_state <= S_E_B;
                end
                S_E_B: begin
                    r_b0    <= BW'(r_e0.pos) + BW'(r_lim) + BW'(1);
                    r_bi    <= BW'(r_pos) + BW'(r_lim) + BW'(1);
                    r_state <= S_E_D;
                end
                S_E_D: begin
                    r_d     <= (BW'(r_pos) >= r_b0) ? BW'(r_pos) - r_b0 : r_b0 - BW'(r_pos);
                    r_state <= S_E_SQ;
                end
                S_E_SQ: r_state <= S_E_F;
                S_E_F: begin
                    if (w_sum[HW-1]) begin
                        r_f   <= HW'(ssp_pkg::COST_MAX);
                        r_ovf <= 1'b1;
                    end else begin
                        r_f   <= w_sum;
                    end
                    r_state <= S_E_YM;
                end
                S_E_YM: r_state <= S_E_YI;
                S_E_YI: begin
                    r_yi    <= r_f + r_mp;
                    r_state <= S_B_RD0;
                end
                // back of the hull
                S_B_RD0: r_state <= (r_live > LW'(1)) ? S_B_RD1 : S_PUSH;
                S_B_RD1: begin
                    r_e1    <= r_rd;
                    r_state <= S_B_L;
                end
                S_B_L: begin
                    r_e0    <= r_rd;
                    r_state <= S_B_B;
                end
                S_B_B: begin
                    r_b0    <= BW'(r_e0.pos) + BW'(r_lim) + BW'(1);
                    r_b1    <= BW'(r_e1.pos) + BW'(r_lim) + BW'(1);
                    r_m1    <= r_e1.pos - r_e0.pos;
                    r_m2    <= r_pos - r_e0.pos;
                    r_state <= S_B_M0;
                end
                S_B_M0: r_state <= S_B_M1;
                S_B_M1: begin
                    r_y0    <= r_e0.h + r_mp;
                    r_state <= S_B_M2;
                end
                S_B_M2: begin
                    r_y1    <= r_e1.h + r_mp;
                    r_state <= S_B_AB;
                end
                S_B_AB: begin
                    r_n1    <= r_yi < r_y0;
                    r_u     <= (r_yi < r_y0) ? r_y0 - r_yi : r_yi - r_y0;
                    r_n2    <= r_y1 < r_y0;
                    r_v     <= (r_y1 < r_y0) ? r_y0 - r_y1 : r_y1 - r_y0;
                    r_state <= S_B_P0;
                end
                S_B_P0: r_state <= S_B_P1;
                S_B_P1: begin
                    r_p1lo  <= r_mp;
                    r_state <= S_B_P2;
                end
                S_B_P2: begin
                    r_p1    <= {r_mp, 32'b0} + PRW'(r_p1lo);
                    r_state <= S_B_P3;
                end
                S_B_P3: begin
                    r_p2lo  <= r_mp;
                    r_state <= S_B_P4;
                end
                S_B_P4: begin
                    r_p2    <= {r_mp, 32'b0} + PRW'(r_p2lo);
                    r_state <= S_B_CMP;
                end
                S_B_CMP: begin
                    if (w_less) begin
                        r_tail  <= ring_prev(r_tail);
                        r_live  <= r_live - LW'(1);
                        r_state <= S_B_RD0;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_live >= DEPTH) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_tail <= ring_next(r_tail);
                        r_live <= r_live + LW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_ovalid <= 1'b1;
                        r_best   <= r_f[ssp_pkg::COST_W-1:0];
                        r_oovf   <= r_ovf;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SSP_ASSERT_CLK(a_live_range, i_clk, i_rst_n, (r_live != '0) && (r_live <= DEPTH), "hull point count out of range")
    `SSP_ASSERT_CLK(a_ring_span, i_clk, i_rst_n, r_live == w_span + LW'(1), "hull count disagrees with head and tail")
    `SSP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, (r_state == S_PUSH) && w_we, r_live < DEPTH, "push into a full hull")
    `SSP_ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_cnt <= ssp_pkg::COUNT_MAX, "item count beyond its limit")

endmodule

`default_nettype wire

// ===== test/tb_squared_slack_partition_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_squared_slack_partition_dp
// self-checking bench for the streaming squared slack partition block
// ---------------------------------------------------------------------------
// Items are sent through the item channel with random gaps and the results
// are taken with random back-pressure. A model of the monotone hull, kept in
// the bench, predicts the cost and overflow flag of every accepted item, and
// each result beat is checked against the oldest prediction. A short table of
// directed items comes first, then random sequences under several limits.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_squared_slack_partition_dp;

    localparam int  DEPTH       = ssp_pkg::HULL_DEPTH_DEF;
    localparam int  N_RANDOM    = 600;
    localparam int  DRAIN_WAIT  = 400;
    localparam longint CYC_LIMIT = 3_000_000;

    typedef struct packed {
        logic [ssp_pkg::COST_W-1:0] cost;
        logic                       ovf;
    } t_cost_beat;

    typedef struct {
        logic [ssp_pkg::ITEM_W-1:0] len;
        logic                       start;
        logic                       typed;
        logic [ssp_pkg::COST_W-1:0] cost;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ssp_pkg::LIMIT_W-1:0] i_cfg_data;

    ssp_item_if   item_ch ();
    ssp_result_if res_ch ();

    squared_slack_partition_dp dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (res_ch.source)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // hull model state
    // ------------------------------------------------------------------
    logic [15:0] cur_limit;
    logic [29:0] pos_sum;
    int unsigned n_items;
    logic [29:0] hpos [DEPTH];
    logic [63:0] hcost [DEPTH];
    int unsigned head, tail;
    logic        ovf_seen;

    t_cost_beat  cost_q[$];
    int          n_errors;
    int          snd_idle_pct;
    int          rcv_stall_pct;
    longint      cyc;

    function automatic int unsigned ring_nx(int unsigned k);
        return (k + 1 >= DEPTH) ? 0 : k + 1;
    endfunction

    function automatic int unsigned ring_pv(int unsigned k);
        return (k == 0) ? DEPTH - 1 : k - 1;
    endfunction

    function automatic int unsigned live_pts();
        return ((tail + DEPTH - head) % DEPTH) + 1;
    endfunction

    // split point height: stored cost plus shifted position squared
    function automatic logic [63:0] height(int unsigned k);
        logic [63:0] b;
        b = 64'(hpos[k]) + 64'(cur_limit) + 64'd1;
        return hcost[k] + b * b;
    endfunction

    function automatic void clear_seq();
        pos_sum  = '0;
        n_items  = 0;
        hpos[0]  = '0;
        hcost[0] = '0;
        head     = 0;
        tail     = 0;
        ovf_seen = 1'b0;
    endfunction

    // exact signed compare (ya - yb) * m1 < (yc - yd) * m2
    function automatic logic slope_less(logic [63:0] ya, logic [63:0] yb, logic [63:0] m1,
                                        logic [63:0] yc, logic [63:0] yd, logic [63:0] m2);
        logic signed [131:0] l, r;
        l = ($signed({68'd0, ya}) - $signed({68'd0, yb})) * $signed({68'd0, m1});
        r = ($signed({68'd0, yc}) - $signed({68'd0, yd})) * $signed({68'd0, m2});
        return l < r;
    endfunction

    function automatic t_cost_beat cost_step(logic [ssp_pkg::ITEM_W-1:0] len, logic st);
        t_cost_beat  res;
        logic [63:0] a, b, y0, y1, yi, f, d, sq;
        logic signed [64:0] df;
        int unsigned k0, k1;
        if (st) clear_seq();
        if (n_items >= int'(ssp_pkg::COUNT_MAX)) begin
            ovf_seen = 1'b1;
            res.cost = ssp_pkg::COST_MAX;
            res.ovf  = 1'b1;
            return res;
        end
        n_items++;
        pos_sum = pos_sum + 30'(len) + 30'd1;
        a = 64'(pos_sum);
        // front pops while the next point is strictly better
        while (live_pts() > 1) begin
            k0 = head;
            k1 = ring_nx(k0);
            y0 = height(k0);
            y1 = height(k1);
            if (y1 < y0 || (y1 - y0) < 64'd2 * a * (64'(hpos[k1]) - 64'(hpos[k0])))
                head = k1;
            else
                break;
        end
        b  = 64'(hpos[head]) + 64'(cur_limit) + 64'd1;
        df = $signed({1'b0, a}) - $signed({1'b0, b});
        d  = (df < 0) ? 64'(-df) : 64'(df);
        sq = d * d;
        f  = hcost[head];
        if (f > 64'(ssp_pkg::COST_MAX) - sq) begin
            f = 64'(ssp_pkg::COST_MAX);
            ovf_seen = 1'b1;
        end else begin
            f = f + sq;
        end
        // back pops keep the hull convex
        b  = a + 64'(cur_limit) + 64'd1;
        yi = f + b * b;
        while (live_pts() > 1) begin
            k1 = tail;
            k0 = ring_pv(k1);
            y0 = height(k0);
            y1 = height(k1);
            if (slope_less(yi, y0, 64'(hpos[k1]) - 64'(hpos[k0]),
                           y1, y0, a - 64'(hpos[k0])))
                tail = k0;
            else
                break;
        end
        if (live_pts() >= DEPTH) begin
            ovf_seen = 1'b1;
        end else begin
            tail        = ring_nx(tail);
            hpos[tail]  = a[29:0];
            hcost[tail] = f;
        end
        res.cost = f[ssp_pkg::COST_W-1:0];
        res.ovf  = ovf_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_cost_beat want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (cost_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result beat: cost %0d ovf %0b",
                             res_ch.best_cost, res_ch.overflow);
            end else begin
                want = cost_q.pop_front();
                if (res_ch.best_cost !== want.cost || res_ch.overflow !== want.ovf) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result mismatch: cost exp %0d got %0d, ovf exp %0b got %0b",
                                 want.cost, res_ch.best_cost, want.ovf, res_ch.overflow);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------
    // one item beat; valid stays up into the next item when there is no gap
    task automatic send_item(logic [ssp_pkg::ITEM_W-1:0] len, logic st, output t_cost_beat got);
        while ($urandom_range(99) < snd_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.item_length <= len;
        item_ch.start_new   <= st;
        do @(posedge i_clk); while (!item_ch.ready);
        got = cost_step(len, st);
        cost_q.push_back(got);
    endtask

    // wait for every result, then write the limit while the block is idle
    task automatic set_limit(logic [ssp_pkg::LIMIT_W-1:0] val);
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cost_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_limit  = val;
    endtask

    // random length: mostly small so groups form, sometimes the full range
    function automatic logic [ssp_pkg::ITEM_W-1:0] rnd_len();
        case ($urandom_range(3))
            0:       return ssp_pkg::ITEM_W'($urandom_range(65535));
            1:       return ssp_pkg::ITEM_W'($urandom_range(15));
            default: return ssp_pkg::ITEM_W'($urandom_range(255));
        endcase
    endfunction

    t_stim_row dir_rows[$];

    initial begin
        t_cost_beat got;
        t_stim_row  r;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        item_ch.valid       = 1'b0;
        item_ch.item_length = '0;
        item_ch.start_new   = 1'b0;
        res_ch.ready        = 1'b0;
        n_errors            = 0;
        snd_idle_pct        = 0;
        rcv_stall_pct       = 0;
        cyc                 = 0;
        cur_limit           = '0;
        clear_seq();

        // directed rows: typed costs only where the hull holds just the origin
        dir_rows = '{
            '{16'd0,     1'b0, 1'b1, 63'd0},
            '{16'd65535, 1'b1, 1'b1, 63'd4294836225},
            '{16'd65535, 1'b0, 1'b0, 63'd0},
            '{16'd0,     1'b1, 1'b1, 63'd0},
            '{16'd0,     1'b0, 1'b0, 63'd0},
            '{16'd1,     1'b0, 1'b0, 63'd0},
            '{16'h5555,  1'b0, 1'b0, 63'd0},
            '{16'hAAAA,  1'b0, 1'b0, 63'd0},
            '{16'd3,     1'b1, 1'b1, 63'd9},
            '{16'd3,     1'b0, 1'b0, 63'd0},
            '{16'd3,     1'b0, 1'b0, 63'd0},
            '{16'd65535, 1'b0, 1'b0, 63'd0},
            '{16'd2,     1'b0, 1'b0, 63'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset limit zero
        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_item(r.len, r.start, got);
            if (r.typed && (got.cost !== r.cost || got.ovf !== 1'b0)) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("directed row %0d: cost exp %0d pred %0d", i, r.cost, got.cost);
            end
        end

        // largest limit, continuing the sequence: limit changed mid-sequence
        set_limit(16'hFFFF);
        for (int i = 0; i < 8; i++) send_item(rnd_len(), 1'b0, got);
        send_item(16'hFFFF, 1'b1, got);
        send_item(16'h0000, 1'b0, got);

        // random part in four idling phases, each under its own limit
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 62; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 62; end
                default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
            endcase
            case (ph)
                0: set_limit(16'd0);
                1: set_limit(ssp_pkg::LIMIT_W'($urandom_range(300)));
                2: set_limit(ssp_pkg::LIMIT_W'($urandom_range(65535)));
                default: set_limit(16'd40);
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_item(rnd_len(), ($urandom_range(99) < 4), got);
        end

        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cost_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && cost_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
